// File: sv/fcsr_pkg.sv
package fcsr_pkg;

  // Opcodes of the input channel.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Fixed widths of the result fields.
  localparam int SPAN_W  = 13;
  localparam int COLOR_W = 24;

  // Depth of the descriptor queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: sv/fcsr_if.sv
interface fcsr_in_if #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) ();
  import fcsr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       radius;
  logic [COLOR_W-1:0]           fill_color;

  modport source (output valid, op, center_x, center_y, radius, fill_color, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, fill_color, output ready);
endinterface

interface fcsr_out_if ();
  import fcsr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SPAN_W-1:0] span_row;
  logic signed [SPAN_W-1:0] span_left;
  logic signed [SPAN_W-1:0] span_right;
  logic [COLOR_W-1:0]       span_color;
  logic                     last_of_step;
  logic                     circle_done;

  modport source (output valid, span_row, span_left, span_right, span_color, last_of_step,
                  circle_done, input ready);
  modport sink   (input valid, span_row, span_left, span_right, span_color, last_of_step,
                  circle_done, output ready);
endinterface

// File: sv/fcsr_front.sv
module fcsr_front
  import fcsr_pkg::*;
#(
  parameter int  COORD_BITS  = 12,
  parameter int  RADIUS_BITS = 10,
  localparam int XW          = RADIUS_BITS + 2,
  localparam int DESC_W      = 2 * COORD_BITS + COLOR_W + 2 * XW + 3
) (
  input  logic              clk,
  input  logic              rst,
  fcsr_in_if.sink           req,
  input  q_status_t         q_stat,
  output logic              push,
  output logic [DESC_W-1:0] desc
);

  localparam int EW = RADIUS_BITS + 4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ctr_x;
    logic signed [COORD_BITS-1:0] ctr_y;
    logic [COLOR_W-1:0]           color;
    logic signed [XW-1:0]         x;
    logic signed [XW-1:0]         y;
    logic                         has_neg;
    logic                         has_x;
    logic                         done;
  } desc_t;

  logic                         active;
  logic signed [XW-1:0]         cur_x;
  logic signed [XW-1:0]         cur_y;
  logic signed [EW-1:0]         err_term;
  logic signed [COORD_BITS-1:0] ctr_x;
  logic signed [COORD_BITS-1:0] ctr_y;
  logic [COLOR_W-1:0]           held_color;

  logic                 accept;
  logic                 run;
  logic signed [XW-1:0] y_next;
  logic signed [XW-1:0] x_dec;
  logic signed [XW-1:0] x_next;
  logic signed [EW-1:0] err_up;
  logic signed [EW-1:0] err_down;
  logic signed [EW-1:0] err_next;
  logic                 err_pos;
  logic                 done;
  desc_t                d;

  assign req.ready = !q_stat.full;
  assign accept    = req.valid && req.ready;

  always_comb begin
    run      = active && !(cur_x < cur_y);
    y_next   = cur_y + XW'(1);
    x_dec    = cur_x - XW'(1);
    // Midpoint update: err += y; y++; err += y, then the x correction.
    err_up   = err_term + EW'(cur_y) + EW'(y_next);
    err_pos  = !err_up[EW-1];
    err_down = err_up - EW'(cur_x) - EW'(x_dec);
    x_next   = err_pos ? x_dec : cur_x;
    err_next = err_pos ? err_down : err_up;
    done     = x_next < y_next;
  end

  always_comb begin
    d.ctr_x   = ctr_x;
    d.ctr_y   = ctr_y;
    d.color   = held_color;
    d.x       = cur_x;
    d.y       = cur_y;
    d.has_neg = cur_y != '0;
    d.has_x   = err_pos && (cur_x != cur_y);
    d.done    = done;
  end

  assign desc = d;
  assign push = accept && (req.op == OP_STEP) && run;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (req.op == OP_START) begin
        active <= 1'b1;
      end else if (!run || done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.op == OP_START) begin
        ctr_x      <= req.center_x;
        ctr_y      <= req.center_y;
        held_color <= req.fill_color;
        cur_x      <= XW'(req.radius);
        cur_y      <= '0;
        err_term   <= EW'(0) - EW'(req.radius);
      end else if (run) begin
        cur_x    <= x_next;
        cur_y    <= y_next;
        err_term <= err_next;
      end
    end
  end

endmodule

// File: sv/fcsr_queue.sv
module fcsr_queue
  import fcsr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_status_t        stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [AW:0]      count;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  assign rdata      = slots[head];
  assign stat.full  = count == (AW + 1)'(DEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (pop) begin
        head <= wrap_inc(head);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wdata;
    end
  end

endmodule

// File: sv/fcsr_back.sv
module fcsr_back
  import fcsr_pkg::*;
#(
  parameter int  COORD_BITS  = 12,
  parameter int  RADIUS_BITS = 10,
  localparam int XW          = RADIUS_BITS + 2,
  localparam int DESC_W      = 2 * COORD_BITS + COLOR_W + 2 * XW + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [DESC_W-1:0] desc,
  input  q_status_t         q_stat,
  output logic              pop,
  fcsr_out_if.source        span
);

  localparam int MW = (COORD_BITS > XW) ? COORD_BITS : XW;
  localparam int SW = ((MW > SPAN_W) ? MW : SPAN_W) + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ctr_x;
    logic signed [COORD_BITS-1:0] ctr_y;
    logic [COLOR_W-1:0]           color;
    logic signed [XW-1:0]         x;
    logic signed [XW-1:0]         y;
    logic                         has_neg;
    logic                         has_x;
    logic                         done;
  } desc_t;

  desc_t                d;
  logic [3:0]           sent;
  logic [3:0]           pending;
  logic [3:0]           pick;
  logic [1:0]           idx;
  logic                 last;
  logic                 advance;
  logic signed [XW-1:0] off;
  logic signed [XW-1:0] half;
  logic signed [SW-1:0] row_w;
  logic signed [SW-1:0] left_w;
  logic signed [SW-1:0] right_w;

  assign d = desc_t'(desc);

  // Span order within a step: +y, -y (half-width x), then +x, -x (half-width y).
  always_comb begin
    pending = {d.has_x, d.has_x, d.has_neg, 1'b1} & ~sent;
    if (pending[0]) begin
      idx = 2'd0;
    end else if (pending[1]) begin
      idx = 2'd1;
    end else if (pending[2]) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    pick = 4'b0001 << idx;
    last = (pending & ~pick) == 4'b0000;
  end

  always_comb begin
    off     = idx[1] ? d.x : d.y;
    half    = idx[1] ? d.y : d.x;
    row_w   = idx[0] ? SW'(d.ctr_y) - SW'(off) : SW'(d.ctr_y) + SW'(off);
    left_w  = SW'(d.ctr_x) - SW'(half);
    right_w = SW'(d.ctr_x) + SW'(half);
  end

  assign advance = !q_stat.empty && (!span.valid || span.ready);
  assign pop     = advance && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      span.valid <= 1'b0;
      sent       <= '0;
    end else if (advance) begin
      span.valid <= 1'b1;
      sent       <= last ? 4'b0000 : (sent | pick);
    end else if (span.ready) begin
      span.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      span.span_row     <= row_w[SPAN_W-1:0];
      span.span_left    <= left_w[SPAN_W-1:0];
      span.span_right   <= right_w[SPAN_W-1:0];
      span.span_color   <= d.color;
      span.last_of_step <= last;
      span.circle_done  <= d.done;
    end
  end

endmodule

// File: sv/filled_circle_span_rasterizer_unit.sv
// Filled-circle span rasterizer, midpoint scheme.
// Input channel req: op selects start (load center, radius, color; no output)
// or step (one iteration of the midpoint loop). Output channel span: one item
// per horizontal span, columns span_left..span_right inclusive, with
// last_of_step on the final span of a step and circle_done on every span of
// the step that finished the circle. Steps with no circle in progress, and the
// step that finds x below y, produce nothing.
// An accepted step is written as a descriptor into the queue, and the back
// registers its spans into the output register. A step yields one to four
// spans, and the output register presents one span per cycle while the
// receiver holds ready high.
// The front takes one item per cycle while the descriptor queue between front
// and back has room, so steps keep being accepted while spans wait.
// Reset (rst, synchronous) drops any circle in progress and empties the queue
// and the output register. When the receiver holds ready low, the current span
// holds, the queue fills and then req.ready falls until space frees up.
module filled_circle_span_rasterizer_unit
  import fcsr_pkg::*;
#(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic      clk,
  input  logic      rst,
  fcsr_in_if.sink   req,
  fcsr_out_if.source span
);

  localparam int XW     = RADIUS_BITS + 2;
  localparam int DESC_W = 2 * COORD_BITS + COLOR_W + 2 * XW + 3;

  logic              q_push;
  logic              q_pop;
  logic [DESC_W-1:0] q_wdata;
  logic [DESC_W-1:0] q_rdata;
  q_status_t         q_stat;

  fcsr_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .q_stat(q_stat),
    .push  (q_push),
    .desc  (q_wdata)
  );

  fcsr_queue #(
    .WIDTH(DESC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  fcsr_back #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .desc  (q_rdata),
    .q_stat(q_stat),
    .pop   (q_pop),
    .span  (span)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("descriptor pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("descriptor popped from an empty queue");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (span.valid && span.last_of_step))
    else $error("step retired without a span marked last");
`endif

endmodule

// File: test/filled_circle_span_rasterizer_unit_test.sv
module filled_circle_span_rasterizer_unit_test
  import fcsr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS   = 12;
  localparam int RADIUS_BITS  = 10;
  localparam int RANDOM_ITEMS = 430;
  localparam int FULL_CIRCLE_STEPS = 60;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct {
    logic signed [SPAN_W-1:0] row;
    logic signed [SPAN_W-1:0] first_col;
    logic signed [SPAN_W-1:0] last_col;
    logic [COLOR_W-1:0]       color;
    logic                     step_end;
    logic                     circ_end;
  } span_t;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_SPAN} row_check_t;

  typedef struct {
    logic       op;
    int         cx;
    int         cy;
    int         radius;
    int         color;
    row_check_t check;
    int         t_row;
    int         t_first;
    int         t_last;
    int         t_color;
  } stim_row_t;

  // Rows typed with CHK_SPAN are zero-radius circles: one pixel at the center.
  stim_row_t directed_plan [26] = '{
    '{OP_STEP,      0,     0,    0, 0,         CHK_NONE,  0,     0,     0,     0},
    '{OP_START, -2048,  2047,    0, 0,         CHK_NONE,  0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_SPAN,  2047, -2048, -2048,  0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_NONE,  0,     0,     0,     0},
    '{OP_START,  2047, -2048,    0, 'hFFFFFF,  CHK_NONE,  0,     0,     0,     0},
    '{OP_STEP,     -1,    -1, 1023, 'hFFFFFF,  CHK_SPAN, -2048,  2047,  2047, 'hFFFFFF},
    '{OP_START,     0,     0,    1, 'h123456,  CHK_NONE,  0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_START,   100,   -50,    5, 'hA5A5A5,  CHK_NONE,  0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_START, -2048, -2048, 1023, 'h5A5A5A,  CHK_NONE,  0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_START,  2047,  2047, 1023, 'h0F0F0F,  CHK_NONE,  0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_START,     0,     0,    3, 'h00FF00,  CHK_NONE,  0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0},
    '{OP_STEP,      0,     0,    0, 0,         CHK_MODEL, 0,     0,     0,     0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  fcsr_in_if #(.COORD_BITS(COORD_BITS), .RADIUS_BITS(RADIUS_BITS)) req_if ();
  fcsr_out_if span_if ();

  filled_circle_span_rasterizer_unit #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .span(span_if)
  );

  always #6 clk = ~clk;

  // Predicted circle state.
  bit                 circ_active = 1'b0;
  int                 circ_x      = 0;
  int                 circ_y      = 0;
  int                 circ_err    = 0;
  int                 circ_cx     = 0;
  int                 circ_cy     = 0;
  logic [COLOR_W-1:0] circ_color  = '0;

  span_t pending_spans [$];
  int    errors      = 0;
  int    cycle_count = 0;
  bit    req_calm    = 1'b0;
  bit    span_calm   = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic span_t circle_span(input int row_ofs, input int half);
    span_t s;
    s.row       = SPAN_W'(circ_cy + row_ofs);
    s.first_col = SPAN_W'(circ_cx - half);
    s.last_col  = SPAN_W'(circ_cx + half);
    s.color     = circ_color;
    s.step_end  = 1'b0;
    s.circ_end  = 1'b0;
    return s;
  endfunction

  // One midpoint iteration per step; spans are filled in emission order.
  function automatic int trace_circle(input logic op_v,
                                      input logic signed [COORD_BITS-1:0] cx,
                                      input logic signed [COORD_BITS-1:0] cy,
                                      input logic [RADIUS_BITS-1:0] radius,
                                      input logic [COLOR_W-1:0] color,
                                      output span_t spans [4]);
    int n;
    int lasty;
    bit done;
    n = 0;
    if (op_v == OP_START) begin
      circ_cx     = cx;
      circ_cy     = cy;
      circ_color  = color;
      circ_x      = int'(radius);
      circ_y      = 0;
      circ_err    = -int'(radius);
      circ_active = 1'b1;
      return 0;
    end
    if (!circ_active) return 0;
    if (circ_x < circ_y) begin
      circ_active = 1'b0;
      return 0;
    end
    lasty    = circ_y;
    circ_err = circ_err + circ_y;
    circ_y   = circ_y + 1;
    circ_err = circ_err + circ_y;
    spans[n] = circle_span(lasty, circ_x);
    n = n + 1;
    if (lasty != 0) begin
      spans[n] = circle_span(-lasty, circ_x);
      n = n + 1;
    end
    if (circ_err >= 0) begin
      if (circ_x != lasty) begin
        spans[n] = circle_span(circ_x, lasty);
        n = n + 1;
        spans[n] = circle_span(-circ_x, lasty);
        n = n + 1;
      end
      circ_err = circ_err - circ_x;
      circ_x   = circ_x - 1;
      circ_err = circ_err - circ_x;
    end
    done = circ_x < circ_y;
    if (done) circ_active = 1'b0;
    for (int i = 0; i < n; i++) spans[i].circ_end = done;
    spans[n-1].step_end = 1'b1;
    return n;
  endfunction

  // Presents one request item, waits for it to be taken and predicts its spans.
  task automatic issue(input logic op_v, input logic signed [COORD_BITS-1:0] cx,
                       input logic signed [COORD_BITS-1:0] cy,
                       input logic [RADIUS_BITS-1:0] radius,
                       input logic [COLOR_W-1:0] color, input bit use_model,
                       output bit ignored);
    int    gap;
    int    n;
    span_t spans [4];
    if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
    gap = req_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op_v;
    req_if.center_x   <= cx;
    req_if.center_y   <= cy;
    req_if.radius     <= radius;
    req_if.fill_color <= color;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    ignored = (op_v == OP_STEP) && !circ_active;
    n = trace_circle(op_v, cx, cy, radius, color, spans);
    if (use_model) begin
      for (int i = 0; i < n; i++) pending_spans.push_back(spans[i]);
    end
  endtask

  function automatic logic [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
  endfunction

  initial begin
    bit                     ignored;
    int                     served;
    int                     steps;
    int                     pick;
    logic [RADIUS_BITS-1:0] radius;
    span_t                  typed;

    req_if.valid      = 1'b0;
    req_if.op         = OP_START;
    req_if.center_x   = '0;
    req_if.center_y   = '0;
    req_if.radius     = '0;
    req_if.fill_color = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      issue(directed_plan[i].op, COORD_BITS'(directed_plan[i].cx),
            COORD_BITS'(directed_plan[i].cy), RADIUS_BITS'(directed_plan[i].radius),
            COLOR_W'(directed_plan[i].color), directed_plan[i].check == CHK_MODEL, ignored);
      if (directed_plan[i].check == CHK_SPAN) begin
        typed.row       = SPAN_W'(directed_plan[i].t_row);
        typed.first_col = SPAN_W'(directed_plan[i].t_first);
        typed.last_col  = SPAN_W'(directed_plan[i].t_last);
        typed.color     = COLOR_W'(directed_plan[i].t_color);
        typed.step_end  = 1'b1;
        typed.circ_end  = 1'b1;
        pending_spans.push_back(typed);
      end
    end

    // Mostly whole circles of small radius; some are cut short by a new start,
    // and a few stray steps land while no circle is in progress.
    served = 0;
    while (served < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        issue(OP_STEP, rand_coord(), rand_coord(), RADIUS_BITS'($urandom),
              COLOR_W'($urandom), 1'b1, ignored);
        if (!ignored) served++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) radius = RADIUS_BITS'($urandom_range(0, 12));
        else if (pick < 9) radius = RADIUS_BITS'($urandom_range(13, 60));
        else radius = RADIUS_BITS'($urandom_range(0, (1 << RADIUS_BITS) - 1));
        issue(OP_START, rand_coord(), rand_coord(), radius, COLOR_W'($urandom), 1'b1,
              ignored);
        served++;
        steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : FULL_CIRCLE_STEPS;
        for (int k = 0; k < steps && circ_active; k++) begin
          issue(OP_STEP, rand_coord(), rand_coord(), RADIUS_BITS'($urandom),
                COLOR_W'($urandom), 1'b1, ignored);
          served++;
        end
      end
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int    gap;
    span_t want;
    span_if.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) span_calm = !span_calm;
      gap = span_calm ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (gap > 0) begin
        span_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      span_if.ready <= 1'b1;
      @(posedge clk);
      while (span_if.valid !== 1'b1) @(posedge clk);
      if (pending_spans.size() == 0) begin
        $error("unexpected span item: row %0d, columns %0d..%0d", span_if.span_row,
               span_if.span_left, span_if.span_right);
        errors++;
      end else begin
        want = pending_spans.pop_front();
        if (span_if.span_row !== want.row) begin
          $error("span_row: expected %0d, got %0d", want.row, span_if.span_row);
          errors++;
        end
        if (span_if.span_left !== want.first_col) begin
          $error("span_left: expected %0d, got %0d", want.first_col, span_if.span_left);
          errors++;
        end
        if (span_if.span_right !== want.last_col) begin
          $error("span_right: expected %0d, got %0d", want.last_col, span_if.span_right);
          errors++;
        end
        if (span_if.span_color !== want.color) begin
          $error("span_color: expected %06h, got %06h", want.color, span_if.span_color);
          errors++;
        end
        if (span_if.last_of_step !== want.step_end) begin
          $error("last_of_step: expected %0b, got %0b", want.step_end, span_if.last_of_step);
          errors++;
        end
        if (span_if.circle_done !== want.circ_end) begin
          $error("circle_done: expected %0b, got %0b", want.circ_end, span_if.circle_done);
          errors++;
        end
      end
    end
  end

endmodule

// File: sim.f
sv/fcsr_pkg.sv
sv/fcsr_if.sv
sv/fcsr_front.sv
sv/fcsr_queue.sv
sv/fcsr_back.sv
sv/filled_circle_span_rasterizer_unit.sv
test/filled_circle_span_rasterizer_unit_test.sv
